### rtl/rv32d_pkg.sv
package rv32d_pkg;

  // Major opcodes, instruction bits 6:0
  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;

  // Function codes, instruction bits 14:12
  localparam logic [2:0] F3_0 = 3'd0;
  localparam logic [2:0] F3_1 = 3'd1;
  localparam logic [2:0] F3_2 = 3'd2;
  localparam logic [2:0] F3_3 = 3'd3;
  localparam logic [2:0] F3_4 = 3'd4;
  localparam logic [2:0] F3_5 = 3'd5;
  localparam logic [2:0] F3_6 = 3'd6;
  localparam logic [2:0] F3_7 = 3'd7;

  localparam int unsigned InWidth  = 32;
  localparam int unsigned OutWidth = 64;

  typedef enum logic [2:0] {
    FMT_R,
    FMT_I,
    FMT_S,
    FMT_B,
    FMT_U,
    FMT_J,
    FMT_X
  } fmt_e;

  typedef enum logic [5:0] {
    OP_LUI, OP_AUIPC, OP_JAL, OP_JALR,
    OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
    OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
    OP_SB, OP_SH, OP_SW,
    OP_ADDI, OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI,
    OP_SLLI, OP_SRLI, OP_SRAI,
    OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA, OP_OR, OP_AND,
    OP_NONE
  } op_e;

  // Stage 1: captured word with its format
  typedef struct packed {
    logic [31:0] word;
    fmt_e        fmt;
  } s1_t;

  // Stage 2: operation, register fields and immediate
  typedef struct packed {
    fmt_e        fmt;
    op_e         op;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
  } s2_t;

  typedef struct packed {
    logic writes_dest;
    logic reads_src1;
    logic reads_src2;
    logic memory_access;
    logic control_transfer;
    logic recognised;
  } flags_t;

  function automatic fmt_e decode_format(input logic [6:0] opc);
    fmt_e fmt;
    case (opc)
      OPC_OP:                         fmt = FMT_R;
      OPC_LOAD, OPC_JALR, OPC_OP_IMM: fmt = FMT_I;
      OPC_STORE:                      fmt = FMT_S;
      OPC_LUI, OPC_AUIPC:             fmt = FMT_U;
      OPC_JAL:                        fmt = FMT_J;
      OPC_BRANCH:                     fmt = FMT_B;
      default:                        fmt = FMT_X;
    endcase
    return fmt;
  endfunction

  function automatic flags_t decode_flags(input op_e op);
    flags_t f;
    logic   is_store;
    logic   is_load;
    logic   is_cbr;
    logic   is_rreg;
    is_store = op inside {[OP_SB:OP_SW]};
    is_load  = op inside {[OP_LB:OP_LHU]};
    is_cbr   = op inside {[OP_BEQ:OP_BGEU]};
    is_rreg  = op inside {[OP_ADD:OP_AND]};
    f.writes_dest      = !(is_store || is_cbr);
    f.reads_src1       = !(op inside {OP_LUI, OP_AUIPC, OP_JAL});
    f.reads_src2       = is_rreg || is_cbr || is_store;
    f.memory_access    = is_load || is_store;
    f.control_transfer = is_cbr || (op == OP_JAL) || (op == OP_JALR);
    f.recognised       = (op != OP_NONE);
    return f;
  endfunction

endpackage

### rtl/rv32d_op_decode.sv
module rv32d_op_decode (
  input  rv32d_pkg::s1_t s1_i,
  output rv32d_pkg::s2_t s2_o
);

  logic [31:0]     w;
  logic [6:0]      opc;
  logic [2:0]      f3;
  logic            f7_nz;
  rv32d_pkg::op_e  op;
  logic [31:0]     imm;

  assign w     = s1_i.word;
  assign opc   = w[6:0];
  assign f3    = w[14:12];
  assign f7_nz = |w[31:25];

  // Pick the operation from format, opcode, funct3 and funct7
  always_comb begin
    op = rv32d_pkg::OP_NONE;
    case (s1_i.fmt)
      rv32d_pkg::FMT_I: begin
        if (opc == rv32d_pkg::OPC_LOAD) begin
          case (f3)
            rv32d_pkg::F3_0: op = rv32d_pkg::OP_LB;
            rv32d_pkg::F3_1: op = rv32d_pkg::OP_LH;
            rv32d_pkg::F3_2: op = rv32d_pkg::OP_LW;
            rv32d_pkg::F3_4: op = rv32d_pkg::OP_LBU;
            rv32d_pkg::F3_5: op = rv32d_pkg::OP_LHU;
            default:         op = rv32d_pkg::OP_NONE;
          endcase
        end else if (opc == rv32d_pkg::OPC_JALR) begin
          op = (f3 == rv32d_pkg::F3_0) ? rv32d_pkg::OP_JALR : rv32d_pkg::OP_NONE;
        end else begin
          case (f3)
            rv32d_pkg::F3_0: op = rv32d_pkg::OP_ADDI;
            rv32d_pkg::F3_1: op = rv32d_pkg::OP_SLLI;
            rv32d_pkg::F3_2: op = rv32d_pkg::OP_SLTI;
            rv32d_pkg::F3_3: op = rv32d_pkg::OP_SLTIU;
            rv32d_pkg::F3_4: op = rv32d_pkg::OP_XORI;
            rv32d_pkg::F3_5: op = f7_nz ? rv32d_pkg::OP_SRAI : rv32d_pkg::OP_SRLI;
            rv32d_pkg::F3_6: op = rv32d_pkg::OP_ORI;
            default:         op = rv32d_pkg::OP_ANDI;
          endcase
        end
      end
      rv32d_pkg::FMT_R: begin
        case (f3)
          rv32d_pkg::F3_0: op = f7_nz ? rv32d_pkg::OP_SUB : rv32d_pkg::OP_ADD;
          rv32d_pkg::F3_1: op = rv32d_pkg::OP_SLL;
          rv32d_pkg::F3_2: op = rv32d_pkg::OP_SLT;
          rv32d_pkg::F3_3: op = rv32d_pkg::OP_SLTU;
          rv32d_pkg::F3_4: op = rv32d_pkg::OP_XOR;
          rv32d_pkg::F3_5: op = f7_nz ? rv32d_pkg::OP_SRA : rv32d_pkg::OP_SRL;
          rv32d_pkg::F3_6: op = rv32d_pkg::OP_OR;
          default:         op = rv32d_pkg::OP_AND;
        endcase
      end
      rv32d_pkg::FMT_U: begin
        op = (opc == rv32d_pkg::OPC_LUI) ? rv32d_pkg::OP_LUI : rv32d_pkg::OP_AUIPC;
      end
      rv32d_pkg::FMT_J: begin
        op = rv32d_pkg::OP_JAL;
      end
      rv32d_pkg::FMT_B: begin
        case (f3)
          rv32d_pkg::F3_0: op = rv32d_pkg::OP_BEQ;
          rv32d_pkg::F3_1: op = rv32d_pkg::OP_BNE;
          rv32d_pkg::F3_4: op = rv32d_pkg::OP_BLT;
          rv32d_pkg::F3_5: op = rv32d_pkg::OP_BGE;
          rv32d_pkg::F3_6: op = rv32d_pkg::OP_BLTU;
          rv32d_pkg::F3_7: op = rv32d_pkg::OP_BGEU;
          default:         op = rv32d_pkg::OP_NONE;
        endcase
      end
      rv32d_pkg::FMT_S: begin
        case (f3)
          rv32d_pkg::F3_0: op = rv32d_pkg::OP_SB;
          rv32d_pkg::F3_1: op = rv32d_pkg::OP_SH;
          rv32d_pkg::F3_2: op = rv32d_pkg::OP_SW;
          default:         op = rv32d_pkg::OP_NONE;
        endcase
      end
      default: op = rv32d_pkg::OP_NONE;
    endcase
  end

  // Assemble the sign-extended immediate of the format
  always_comb begin
    case (s1_i.fmt)
      rv32d_pkg::FMT_I: imm = {{20{w[31]}}, w[31:20]};
      rv32d_pkg::FMT_S: imm = {{20{w[31]}}, w[31:25], w[11:7]};
      rv32d_pkg::FMT_B: imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      rv32d_pkg::FMT_U: imm = {w[31:12], 12'h000};
      rv32d_pkg::FMT_J: imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      default:          imm = 32'h0000_0000;
    endcase
  end

  assign s2_o.fmt = s1_i.fmt;
  assign s2_o.op  = op;
  assign s2_o.rd  = w[11:7];
  assign s2_o.rs1 = w[19:15];
  assign s2_o.rs2 = w[24:20];
  assign s2_o.imm = imm;

endmodule

### rtl/rv32i_instruction_decoder_unit.sv
// RV32I instruction decoder. Each 32-bit instruction word taken on the slave
// stream yields one result on the master stream: format, operation number (37
// when not recognised), rd/rs1/rs2, the sign-extended immediate and usage flags.
// The decoder is a three-stage pipeline (opcode/format, operation/immediate,
// flags and output register): a taken word is registered in stage 1, moves
// through stage 2 and is offered from the stage 3 output register. One word is
// taken every cycle while the master side keeps tready high. Each stage holds
// its own valid bit, so empty stages fill even while a result waits at the output.
module rv32i_instruction_decoder_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: [31:0] instruction_word
  input  logic [rv32d_pkg::InWidth-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: [2:0] format, [8:3] operation, [13:9] dest_reg, [18:14] src1_reg,
  // [23:19] src2_reg, [55:24] immediate, [56] writes_dest, [57] reads_src1,
  // [58] reads_src2, [59] memory_access, [60] control_transfer,
  // [61] recognised, [63:62] zero
  output logic [rv32d_pkg::OutWidth-1:0]     m_axis_tdata
);

  logic              s1_valid_q, s1_valid_d;
  logic              s2_valid_q, s2_valid_d;
  logic              s3_valid_q, s3_valid_d;
  logic              s1_ready, s2_ready, s3_ready;
  rv32d_pkg::s1_t    s1_q, s1_d;
  rv32d_pkg::s2_t    s2_q, s2_d;
  rv32d_pkg::s2_t    s3_q;
  rv32d_pkg::flags_t s3_flags_q, s3_flags_d;

  // A stage may load when it is empty or its content moves on
  assign s3_ready      = !s3_valid_q || m_axis_tready;
  assign s2_ready      = !s2_valid_q || s3_ready;
  assign s1_ready      = !s1_valid_q || s2_ready;
  assign s_axis_tready = s1_ready;

  // Stage 1: capture the word and decode its format
  assign s1_valid_d = s1_ready ? s_axis_tvalid : s1_valid_q;
  assign s1_d.word  = s_axis_tdata;
  assign s1_d.fmt   = rv32d_pkg::decode_format(s_axis_tdata[6:0]);

  // Stage 2: operation and immediate
  rv32d_op_decode u_op_decode (
    .s1_i (s1_q),
    .s2_o (s2_d)
  );
  assign s2_valid_d = s2_ready ? s1_valid_q : s2_valid_q;

  // Stage 3: usage flags, output register
  assign s3_flags_d = rv32d_pkg::decode_flags(s2_q.op);
  assign s3_valid_d = s3_ready ? s2_valid_q : s3_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      s3_valid_q <= s3_valid_d;
    end
  end

  // Advance payloads only into a stage that is free
  always_ff @(posedge clk_i) begin
    if (s1_ready && s_axis_tvalid) begin
      s1_q <= s1_d;
    end
    if (s2_ready && s1_valid_q) begin
      s2_q <= s2_d;
    end
    if (s3_ready && s2_valid_q) begin
      s3_q       <= s2_q;
      s3_flags_q <= s3_flags_d;
    end
  end

  assign m_axis_tvalid = s3_valid_q;
  assign m_axis_tdata  = {2'b00,
                          s3_flags_q.recognised,
                          s3_flags_q.control_transfer,
                          s3_flags_q.memory_access,
                          s3_flags_q.reads_src2,
                          s3_flags_q.reads_src1,
                          s3_flags_q.writes_dest,
                          s3_q.imm,
                          s3_q.rs2,
                          s3_q.rs1,
                          s3_q.rd,
                          s3_q.op,
                          s3_q.fmt};

  // An empty output stage leaves the whole pipe free to take a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s3_valid_q |-> s_axis_tready)
    else $error("input stalled while output stage empty");

  // A taken transaction always lands in stage 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> s1_valid_q)
    else $error("accepted word lost at stage 1");

  // A stage holding data that cannot move keeps its valid bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !s3_ready) |=> s2_valid_q)
    else $error("stage 2 dropped a stalled item");

  // Recognised flag agrees with the operation number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> (s3_flags_q.recognised == (s3_q.op != rv32d_pkg::OP_NONE)))
    else $error("recognised flag disagrees with operation");

  // Unknown format gives no operation and a zero immediate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && (s3_q.fmt == rv32d_pkg::FMT_X)) |->
      (!s3_flags_q.recognised && (s3_q.imm == 32'h0000_0000)))
    else $error("unknown format decoded as an operation");

endmodule
